// ===== rtl/core/gft_pkg.sv =====
// Shared types, character codes and helper functions for the grammar file tokenizer.
// Used by gft_ctrl, gft_dpath and grammar_file_tokenizer_unit; depends on nothing.
package gft_pkg;

  // Lookahead store depth and default length cap
  localparam int LA_DEPTH              = 6;
  localparam int CNT_W                 = $clog2(LA_DEPTH + 1);
  localparam int MAX_TOKEN_LEN_DEFAULT = 255;
  localparam int BYTE_MAX              = 255;

  // Source characters that steer the scanner
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_D   = 8'h64;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_K   = 8'h6B;
  localparam logic [7:0] CH_LC_M   = 8'h6D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_LC_P   = 8'h70;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_Y   = 8'h79;

  // Lookahead count at which the final keyword letter is checked
  localparam logic [CNT_W-1:0] PCT_CODE_LAST  = CNT_W'(3);
  localparam logic [CNT_W-1:0] PCT_UNION_LAST = CNT_W'(4);

  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_BLOCK   = 4'd1,
    KIND_TOKKW   = 4'd2,
    KIND_TYPEKW  = 4'd3,
    KIND_PARAMKW = 4'd4,
    KIND_COLON   = 4'd5,
    KIND_LESS    = 4'd6,
    KIND_GREATER = 4'd7,
    KIND_BAR     = 4'd8,
    KIND_SEMI    = 4'd9,
    KIND_SIGN    = 4'd10,
    KIND_CODE    = 4'd11,
    KIND_UNION   = 4'd12,
    KIND_END     = 4'd13,
    KIND_UNKNOWN = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_AT    = 3'd3,
    MODE_PCT   = 3'd4
  } mode_t;

  // At-word keyword matcher progress
  typedef enum logic [3:0] {
    KW_IDLE  = 4'd0,
    KW_AT    = 4'd1,
    KW_T     = 4'd2,
    KW_TO    = 4'd3,
    KW_TOK   = 4'd4,
    KW_TOKE  = 4'd5,
    KW_TOKEN = 4'd6,
    KW_TY    = 4'd7,
    KW_TYP   = 4'd8,
    KW_TYPE  = 4'd9,
    KW_P     = 4'd10,
    KW_PA    = 4'd11,
    KW_PAR   = 4'd12,
    KW_PARA  = 4'd13,
    KW_PARAM = 4'd14,
    KW_NONE  = 4'd15
  } kw_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CUR    = 2'd1,
    ST_REPLAY = 2'd2,
    ST_FLUSH  = 2'd3
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       is_value_char;
    logic [7:0] value_char;
    logic       token_end;
    kind_t      token_kind;
    logic [7:0] token_length;
    logic       last_of_run;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_cur;
    logic scan_replay;
    logic flush;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_go;
    logic scan_consume;
    logic scan_replay;
    logic flush_end;
    logic flush_replay;
    logic replay_last;
    logic last_in;
  } dp_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic kw_t kw_next(input kw_t p, input logic [7:0] c);
    kw_t r;
    r = KW_NONE;
    unique case (p)
      KW_AT:   r = (c == CH_LC_T) ? KW_T : ((c == CH_LC_P) ? KW_P : KW_NONE);
      KW_T:    r = (c == CH_LC_O) ? KW_TO : ((c == CH_LC_Y) ? KW_TY : KW_NONE);
      KW_TO:   r = (c == CH_LC_K) ? KW_TOK : KW_NONE;
      KW_TOK:  r = (c == CH_LC_E) ? KW_TOKE : KW_NONE;
      KW_TOKE: r = (c == CH_LC_N) ? KW_TOKEN : KW_NONE;
      KW_TY:   r = (c == CH_LC_P) ? KW_TYP : KW_NONE;
      KW_TYP:  r = (c == CH_LC_E) ? KW_TYPE : KW_NONE;
      KW_P:    r = (c == CH_LC_A) ? KW_PA : KW_NONE;
      KW_PA:   r = (c == CH_LC_R) ? KW_PAR : KW_NONE;
      KW_PAR:  r = (c == CH_LC_A) ? KW_PARA : KW_NONE;
      KW_PARA: r = (c == CH_LC_M) ? KW_PARAM : KW_NONE;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

  // Class an at-word by the matcher's final progress
  function automatic kind_t at_kind(input kw_t p);
    kind_t k;
    unique case (p)
      KW_TOKEN: k = KIND_TOKKW;
      KW_TYPE:  k = KIND_TYPEKW;
      KW_PARAM: k = KIND_PARAMKW;
      default:  k = KIND_BLOCK;
    endcase
    return k;
  endfunction

  // Expected next letter after a percent sign: {valid, char}
  function automatic logic [8:0] pct_want(input logic is_code, input logic [CNT_W-1:0] n);
    logic [8:0] w;
    w = '0;
    if (is_code) begin
      unique case (n)
        CNT_W'(1): w = {1'b1, CH_LC_O};
        CNT_W'(2): w = {1'b1, CH_LC_D};
        CNT_W'(3): w = {1'b1, CH_LC_E};
        default:   w = '0;
      endcase
    end else begin
      unique case (n)
        CNT_W'(1): w = {1'b1, CH_LC_N};
        CNT_W'(2): w = {1'b1, CH_LC_I};
        CNT_W'(3): w = {1'b1, CH_LC_O};
        CNT_W'(4): w = {1'b1, CH_LC_N};
        default:   w = '0;
      endcase
    end
    return w;
  endfunction

  function automatic out_item_t rec_char(input logic [7:0] c);
    out_item_t r;
    r = '0;
    r.is_value_char = 1'b1;
    r.value_char    = c;
    r.token_kind    = KIND_IDENT;
    return r;
  endfunction

  function automatic out_item_t rec_end(input kind_t k, input logic [7:0] len);
    out_item_t r;
    r = '0;
    r.token_end    = 1'b1;
    r.token_kind   = k;
    r.token_length = len;
    return r;
  endfunction

endpackage

// ===== rtl/core/gft_ctrl.sv =====
// Sequencing controller of the grammar file tokenizer: input acceptance,
// replay of lookahead bytes and end-of-input flush. Depends on gft_pkg.
module gft_ctrl import gft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;
  logic       flushing, flushing_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    cmd           = '0;
    byte_stall    = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (byte_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CUR;
        end
      end
      ST_CUR: begin
        if (status.can_go) begin
          cmd.scan_cur = 1'b1;
          if (status.scan_consume) begin
            if (status.last_in) begin
              state_next    = ST_FLUSH;
              flushing_next = 1'b1;
            end else begin
              state_next = ST_IDLE;
              cmd.finish = 1'b1;
            end
          end else if (status.scan_replay) begin
            state_next = ST_REPLAY;
          end
        end
      end
      ST_REPLAY: begin
        if (status.can_go) begin
          cmd.scan_replay = 1'b1;
          if (status.scan_consume && status.replay_last) begin
            state_next = flushing ? ST_FLUSH : ST_CUR;
          end
        end
      end
      ST_FLUSH: begin
        if (status.can_go) begin
          cmd.flush = 1'b1;
          if (status.flush_end) begin
            state_next    = ST_IDLE;
            flushing_next = 1'b0;
            cmd.finish    = 1'b1;
          end else if (status.flush_replay) begin
            state_next = ST_REPLAY;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/gft_dpath.sv =====
// Datapath of the grammar file tokenizer: scan state, lookahead store,
// record generation and the pending/output registers. Depends on gft_pkg.
module gft_dpath import gft_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   byte_item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       tok_valid,
  input  logic       tok_stall,
  output out_item_t  tok_item
);

  localparam logic [7:0] LEN_CAP =
    8'((MAX_TOKEN_LEN < BYTE_MAX) ? MAX_TOKEN_LEN : BYTE_MAX);

  typedef struct packed {
    logic             emit;
    out_item_t        rec;
    logic             consume;
    logic             replay;
    logic             done;
    logic             wr;
    mode_t            mode;
    logic [7:0]       len;
    kw_t              kwp;
    logic [CNT_W-1:0] cnt;
    logic             halted;
    logic             is_code;
  } step_t;

  // Scan state
  mode_t            mode;
  logic [7:0]       len;
  kw_t              kwp;
  logic [CNT_W-1:0] cnt;
  logic             halted;
  logic             pct_is_code;
  logic [CNT_W-1:0] rep_left;
  logic [7:0]       la_store [LA_DEPTH];

  // Latched input item
  logic [7:0] cur_byte;
  logic       last_in;

  // One record held back until its successor or the end of the run is known
  logic      pend_valid;
  out_item_t pend;
  out_item_t rec_fin;

  logic       out_free, can_go, move_out, act_scan, act, emit_now;
  logic [7:0] b, len_inc;
  logic [8:0] want;
  step_t      s, f, u;

  assign b       = (rep_left != '0) ? la_store[0] : cur_byte;
  assign len_inc = (len < LEN_CAP) ? len + 8'd1 : len;
  assign want    = pct_want(pct_is_code, cnt);

  // Evaluate one scanned byte
  always_comb begin
    s         = '0;
    s.mode    = mode;
    s.len     = len;
    s.kwp     = kwp;
    s.cnt     = cnt;
    s.halted  = halted;
    s.is_code = pct_is_code;
    if (halted) begin
      s.consume = 1'b1;
    end else begin
      unique case (mode)
        MODE_IDENT: begin
          s.emit = 1'b1;
          if (is_letter(b) || (b == CH_UNDER)) begin
            s.rec     = rec_char(b);
            s.len     = len_inc;
            s.consume = 1'b1;
          end else begin
            s.rec  = rec_end(KIND_IDENT, len);
            s.mode = MODE_IDLE;
            s.len  = '0;
          end
        end
        MODE_BLOCK: begin
          s.emit    = 1'b1;
          s.consume = 1'b1;
          if (b == CH_RBRACE) begin
            s.rec  = rec_end(KIND_BLOCK, len);
            s.mode = MODE_IDLE;
            s.len  = '0;
          end else begin
            s.rec = rec_char(b);
            s.len = len_inc;
          end
        end
        MODE_AT: begin
          s.emit    = 1'b1;
          s.consume = 1'b1;
          if (b == CH_SPACE) begin
            s.rec  = rec_end(at_kind(kwp), len);
            s.mode = MODE_IDLE;
            s.len  = '0;
            s.kwp  = KW_IDLE;
          end else begin
            s.rec = rec_char(b);
            s.len = len_inc;
            s.kwp = kw_next(kwp, b);
          end
        end
        MODE_PCT: begin
          if (cnt == '0) begin
            if ((b == CH_LC_C) || (b == CH_LC_U)) begin
              s.wr      = 1'b1;
              s.is_code = (b == CH_LC_C);
              s.cnt     = CNT_W'(1);
              s.consume = 1'b1;
            end else begin
              // Lone sign; rescan this byte from idle
              s.emit = 1'b1;
              s.rec  = rec_end(KIND_SIGN, 8'd0);
              s.mode = MODE_IDLE;
            end
          end else if (want[8] && (b == want[7:0])) begin
            s.wr      = 1'b1;
            s.cnt     = cnt + CNT_W'(1);
            s.consume = 1'b1;
            if ((pct_is_code && (cnt == PCT_CODE_LAST)) ||
                (!pct_is_code && (cnt == PCT_UNION_LAST))) begin
              s.emit = 1'b1;
              s.rec  = rec_end(pct_is_code ? KIND_CODE : KIND_UNION, 8'd0);
              s.mode = MODE_IDLE;
              s.cnt  = '0;
            end
          end else begin
            // Mismatch: sign, then replay the buffered letters
            s.emit   = 1'b1;
            s.rec    = rec_end(KIND_SIGN, 8'd0);
            s.mode   = MODE_IDLE;
            s.cnt    = '0;
            s.replay = 1'b1;
          end
        end
        default: begin
          // Between tokens
          s.consume = 1'b1;
          if (is_letter(b)) begin
            s.emit = 1'b1;
            s.rec  = rec_char(b);
            s.mode = MODE_IDENT;
            s.len  = 8'd1;
          end else begin
            unique case (b)
              CH_SPACE, CH_NL: s.emit = 1'b0;
              CH_COLON: begin
                s.emit = 1'b1;
                s.rec  = rec_end(KIND_COLON, 8'd0);
              end
              CH_LESS: begin
                s.emit = 1'b1;
                s.rec  = rec_end(KIND_LESS, 8'd0);
              end
              CH_GREAT: begin
                s.emit = 1'b1;
                s.rec  = rec_end(KIND_GREATER, 8'd0);
              end
              CH_BAR: begin
                s.emit = 1'b1;
                s.rec  = rec_end(KIND_BAR, 8'd0);
              end
              CH_SEMI: begin
                s.emit = 1'b1;
                s.rec  = rec_end(KIND_SEMI, 8'd0);
              end
              CH_LBRACE: begin
                s.mode = MODE_BLOCK;
                s.len  = '0;
              end
              CH_AT: begin
                s.emit = 1'b1;
                s.rec  = rec_char(b);
                s.mode = MODE_AT;
                s.len  = 8'd1;
                s.kwp  = KW_AT;
              end
              CH_PCT: begin
                s.mode = MODE_PCT;
                s.cnt  = '0;
              end
              default: begin
                s.emit   = 1'b1;
                s.rec    = rec_end(KIND_UNKNOWN, 8'd0);
                s.halted = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Evaluate one end-of-input flush step
  always_comb begin
    f         = '0;
    f.emit    = 1'b1;
    f.mode    = MODE_IDLE;
    f.len     = '0;
    f.kwp     = kwp;
    f.cnt     = cnt;
    f.halted  = halted;
    f.is_code = pct_is_code;
    if (halted) begin
      f.rec    = rec_end(KIND_END, 8'd0);
      f.done   = 1'b1;
      f.kwp    = KW_IDLE;
      f.cnt    = '0;
      f.halted = 1'b0;
    end else begin
      unique case (mode)
        MODE_PCT: begin
          f.rec    = rec_end(KIND_SIGN, 8'd0);
          f.cnt    = '0;
          f.replay = (cnt != '0);
        end
        MODE_IDENT: f.rec = rec_end(KIND_IDENT, len);
        MODE_BLOCK: f.rec = rec_end(KIND_BLOCK, len);
        MODE_AT: begin
          f.rec = rec_end(at_kind(kwp), len);
          f.kwp = KW_IDLE;
        end
        default: begin
          f.rec  = rec_end(KIND_END, 8'd0);
          f.done = 1'b1;
          f.kwp  = KW_IDLE;
          f.cnt  = '0;
        end
      endcase
    end
  end

  assign act_scan = cmd.scan_cur | cmd.scan_replay;
  assign act      = act_scan | cmd.flush;
  assign u        = cmd.flush ? f : s;
  assign emit_now = act & u.emit;

  // Mark the new record final when it ends the run
  always_comb begin
    rec_fin             = u.rec;
    rec_fin.last_of_run = cmd.finish;
  end

  assign out_free = !tok_valid || !tok_stall;
  assign can_go   = !pend_valid || out_free;
  assign move_out = pend_valid && out_free && (pend.last_of_run || emit_now);

  always_comb begin
    status              = '0;
    status.can_go       = can_go;
    status.scan_consume = s.consume;
    status.scan_replay  = s.replay;
    status.flush_end    = f.done;
    status.flush_replay = f.replay;
    status.replay_last  = (rep_left == CNT_W'(1));
    status.last_in      = last_in;
  end

  // Scan state and record registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      len        <= '0;
      kwp        <= KW_IDLE;
      cnt        <= '0;
      halted     <= 1'b0;
      rep_left   <= '0;
      pend_valid <= 1'b0;
      tok_valid  <= 1'b0;
    end else begin
      if (act) begin
        mode   <= u.mode;
        len    <= u.len;
        kwp    <= u.kwp;
        cnt    <= u.cnt;
        halted <= u.halted;
      end
      if (act && u.replay) begin
        rep_left <= cnt;
      end else if (cmd.scan_replay && s.consume) begin
        rep_left <= rep_left - CNT_W'(1);
      end
      // Hold back the newest record; mark it final at the end of the run
      if (emit_now) begin
        pend_valid <= 1'b1;
        pend       <= rec_fin;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end else if (cmd.finish && pend_valid) begin
        pend.last_of_run <= 1'b1;
      end
      if (move_out) begin
        tok_valid <= 1'b1;
        tok_item  <= pend;
      end else if (tok_valid && !tok_stall) begin
        tok_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_byte <= byte_item.in_byte;
      last_in  <= byte_item.end_of_input;
    end
    if (act_scan) begin
      pct_is_code <= s.is_code;
    end
  end

  // Lookahead store: append after the sign, shift down while replaying
  always_ff @(posedge clk) begin
    if (act_scan && s.wr) begin
      la_store[cnt] <= b;
    end else if (cmd.scan_replay && s.consume) begin
      for (int i = 0; i < LA_DEPTH - 1; i++) begin
        la_store[i] <= la_store[i+1];
      end
    end
  end

endmodule

// ===== rtl/core/grammar_file_tokenizer_unit.sv =====
// Grammar file tokenizer: streaming scanner from source bytes to token records.
// Channels: byte_* carries one source byte with an end flag per item; tok_*
// carries one record per item (a value character or a token-end record with
// kind and saturated length), last_of_run marking the final record of a byte.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Flow: a byte is taken while the controller is idle and then scanned in the
// ST_CUR state. A byte that closes an identifier or follows a lone percent sign
// is scanned again from idle; a failed percent-keyword lookahead replays each
// buffered byte (up to four) through the scanner. The end flag adds a flush
// step per closing record, the end record included. The single scan unit
// handles one byte a cycle while no held-back record blocks it, and takes no
// new byte until the current one is finished. The last record of a byte
// appears once the scan of that byte has finished.
// Reset: synchronous, active high; returns to idle between tokens, no record
// pending. A stalled output holds its record; the scanner then waits while a
// record is held back behind it, and byte_stall stays high until the item ends.
// Depends on gft_pkg, gft_ctrl and gft_dpath.
module grammar_file_tokenizer_unit import gft_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_item,
  output logic      tok_valid,
  input  logic      tok_stall,
  output out_item_t tok_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  gft_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Scanner and output registers
  gft_dpath #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .byte_item (byte_item),
    .cmd       (cmd),
    .status    (status),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for grammar_file_tokenizer_unit: streams source bytes and
// checks every token record against a scanner model kept in this module.
// Depends on gft_pkg for the item structs and the token kind codes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gft_pkg::*;

  localparam int LEN_CAP          = 255;
  localparam int MAX_RECS_PER_ITEM = 12;
  localparam int RANDOM_ITEMS     = 410;
  localparam int LONG_BLOCK_LEN   = 260;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_item_t  byte_item = '0;
  logic      tok_valid;
  logic      tok_stall = 1'b0;
  out_item_t tok_item;

  grammar_file_tokenizer_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_item   (tok_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Source bytes still to send and token records still to arrive
  in_item_t  source_q[$];
  out_item_t token_records_q[$];

  int  accepted_cnt = 0;
  int  record_cnt = 0;
  int  mismatch_cnt = 0;
  int  total_items = 0;
  int  phase = 0;
  int  tx_idle_pct = 36;
  int  rx_idle_pct = 62;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  byte_taken = 1'b0;
  bit  kinds_seen [15];

  // Scanner model state
  mode_t      scan_md;
  int         cur_len;
  logic [7:0] at_chars [7];
  int         at_n;
  logic [7:0] pct_buf [6];
  int         pct_cnt;
  bit         halted_st;
  int         recs_this_item;

  function automatic void clear_scanner();
    scan_md   = MODE_IDLE;
    cur_len   = 0;
    at_n      = 0;
    pct_cnt   = 0;
    halted_st = 1'b0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void push_record(out_item_t r);
    if (recs_this_item < MAX_RECS_PER_ITEM) begin
      token_records_q.push_back(r);
      recs_this_item++;
    end
  endfunction

  function automatic void push_value_char(logic [7:0] c);
    out_item_t r;
    r = '0;
    r.is_value_char = 1'b1;
    r.value_char    = c;
    r.token_kind    = KIND_IDENT;
    push_record(r);
    if (cur_len < LEN_CAP) cur_len++;
  endfunction

  function automatic void push_token_end(kind_t k, int len);
    out_item_t r;
    r = '0;
    r.token_end    = 1'b1;
    r.token_kind   = k;
    r.token_length = (len > LEN_CAP) ? 8'(LEN_CAP) : 8'(len);
    push_record(r);
  endfunction

  function automatic bit at_word_is(string w);
    int i;
    if (at_n != w.len()) return 1'b0;
    for (i = 0; i < w.len(); i++)
      if (at_chars[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void close_at_word();
    kind_t k;
    if (at_word_is("@token")) k = KIND_TOKKW;
    else if (at_word_is("@type")) k = KIND_TYPEKW;
    else if (at_word_is("@param")) k = KIND_PARAMKW;
    else k = KIND_BLOCK;
    push_token_end(k, cur_len);
    scan_md = MODE_IDLE;
    cur_len = 0;
    at_n    = 0;
  endfunction

  // Failed percent keyword: emit the sign, then rescan the held bytes from idle
  function automatic void replay_lookahead();
    logic [7:0] held [6];
    int         n;
    int         i;
    n    = pct_cnt;
    held = pct_buf;
    push_token_end(KIND_SIGN, 0);
    scan_md = MODE_IDLE;
    pct_cnt = 0;
    for (i = 0; i < n; i++) scan_char(held[i]);
  endfunction

  function automatic void scan_from_idle(logic [7:0] c);
    if (is_alpha(c)) begin
      scan_md = MODE_IDENT;
      cur_len = 0;
      push_value_char(c);
      return;
    end
    case (c)
      CH_SPACE, CH_NL: ;
      CH_COLON: push_token_end(KIND_COLON, 0);
      CH_LESS:  push_token_end(KIND_LESS, 0);
      CH_GREAT: push_token_end(KIND_GREATER, 0);
      CH_BAR:   push_token_end(KIND_BAR, 0);
      CH_SEMI:  push_token_end(KIND_SEMI, 0);
      CH_LBRACE: begin
        scan_md = MODE_BLOCK;
        cur_len = 0;
      end
      CH_AT: begin
        scan_md     = MODE_AT;
        cur_len     = 0;
        at_chars[0] = c;
        at_n        = 1;
        push_value_char(c);
      end
      CH_PCT: begin
        scan_md = MODE_PCT;
        pct_cnt = 0;
      end
      default: begin
        push_token_end(KIND_UNKNOWN, 0);
        halted_st = 1'b1;
      end
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int    n;
    string pct_word;
    if (halted_st) return;
    case (scan_md)
      MODE_IDENT: begin
        if (is_alpha(c) || c == CH_UNDER) begin
          push_value_char(c);
        end else begin
          push_token_end(KIND_IDENT, cur_len);
          scan_md = MODE_IDLE;
          cur_len = 0;
          scan_from_idle(c);
        end
      end
      MODE_BLOCK: begin
        if (c == CH_RBRACE) begin
          push_token_end(KIND_BLOCK, cur_len);
          scan_md = MODE_IDLE;
          cur_len = 0;
        end else begin
          push_value_char(c);
        end
      end
      MODE_AT: begin
        if (c == CH_SPACE) begin
          close_at_word();
        end else begin
          push_value_char(c);
          if (at_n < 7) begin
            at_chars[at_n] = c;
            at_n++;
          end
        end
      end
      MODE_PCT: begin
        n = pct_cnt;
        if (n == 0) begin
          if (c == CH_LC_C || c == CH_LC_U) begin
            pct_buf[0] = c;
            pct_cnt    = 1;
          end else begin
            replay_lookahead();
            scan_char(c);
          end
          return;
        end
        if (pct_buf[0] == CH_LC_C) pct_word = "code";
        else pct_word = "union";
        if (n >= pct_word.len() || c != pct_word[n]) begin
          replay_lookahead();
          scan_char(c);
          return;
        end
        pct_buf[n] = c;
        pct_cnt    = n + 1;
        if (pct_cnt == pct_word.len()) begin
          push_token_end((pct_buf[0] == CH_LC_C) ? KIND_CODE : KIND_UNION, 0);
          scan_md = MODE_IDLE;
          pct_cnt = 0;
        end
      end
      default: scan_from_idle(c);
    endcase
  endfunction

  // Work out every record that one accepted source item causes
  function automatic void tokenize_item(in_item_t it);
    recs_this_item = 0;
    scan_char(it.in_byte);
    if (it.end_of_input) begin
      if (!halted_st) begin
        if (scan_md == MODE_PCT) replay_lookahead();
        if (scan_md == MODE_IDENT) push_token_end(KIND_IDENT, cur_len);
        else if (scan_md == MODE_BLOCK) push_token_end(KIND_BLOCK, cur_len);
        else if (scan_md == MODE_AT) close_at_word();
      end
      push_token_end(KIND_END, 0);
      clear_scanner();
    end
    if (recs_this_item > 0)
      token_records_q[token_records_q.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  task automatic check_record(out_item_t got);
    out_item_t want;
    if (token_records_q.size() == 0) begin
      $display("%0t: unexpected record %0h, expected none", $time, got);
      mismatch_cnt++;
      return;
    end
    want = token_records_q.pop_front();
    compare_field("is_value_char", 8'(want.is_value_char), 8'(got.is_value_char));
    compare_field("value_char", want.value_char, got.value_char);
    compare_field("token_end", 8'(want.token_end), 8'(got.token_end));
    compare_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
    compare_field("token_length", want.token_length, got.token_length);
    compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    if (got.token_end === 1'b1 && got.token_kind <= KIND_UNKNOWN) kinds_seen[got.token_kind] = 1'b1;
  endtask

  // Monitor: check delivered records, predict from accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_valid && !tok_stall) begin
        record_cnt++;
        check_record(tok_item);
      end
      if (byte_valid && !byte_stall) begin
        tokenize_item(byte_item);
        accepted_cnt++;
        byte_taken = 1'b1;
      end
    end
  end

  // Driver: hold a stalled item, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      if (source_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        byte_item  <= source_q.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  // Receiver: random stalls, and one long hold-off when the last phase begins
  always @(negedge clk) begin
    if (rst) begin
      tok_stall <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      tok_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      tok_stall <= 1'b1;
    end else begin
      tok_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic put_item(logic [7:0] b, bit eoi);
    in_item_t it;
    it.in_byte      = b;
    it.end_of_input = eoi;
    source_q.push_back(it);
  endtask

  function automatic bit rand_end();
    return ($urandom_range(0, 39) == 0);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_NL;
      2: return CH_COLON;
      3: return CH_LESS;
      4: return CH_GREAT;
      5: return CH_BAR;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] rand_except(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  // Append one well-formed or broken token fragment with random content
  task automatic add_fragment();
    int    sel;
    int    n;
    int    cut;
    int    i;
    string kw;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      put_item(rand_letter(), rand_end());
      n = $urandom_range(0, 7);
      repeat (n) put_item(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_letter(), rand_end());
      put_item(rand_separator(), rand_end());
    end else if (sel < 32) begin
      put_item(CH_LBRACE, rand_end());
      n = $urandom_range(0, 10);
      repeat (n) put_item(rand_except(CH_RBRACE), rand_end());
      put_item(CH_RBRACE, rand_end());
    end else if (sel < 48) begin
      put_item(CH_AT, rand_end());
      case ($urandom_range(0, 3))
        0: kw = "token";
        1: kw = "type";
        2: kw = "param";
        default: kw = "";
      endcase
      if (kw.len() != 0) begin
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kw.len()) : kw.len();
        for (i = 0; i < cut; i++) put_item(kw[i], rand_end());
        if ($urandom_range(0, 4) == 0) put_item(rand_letter(), rand_end());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) put_item(rand_except(CH_SPACE), rand_end());
      end
      if ($urandom_range(0, 3) == 0) put_item(CH_NL, rand_end());
      put_item(CH_SPACE, rand_end());
    end else if (sel < 64) begin
      kw = $urandom_range(0, 1) ? "code" : "union";
      put_item(CH_PCT, rand_end());
      cut = $urandom_range(0, 1) ? kw.len() : $urandom_range(0, kw.len() - 1);
      for (i = 0; i < cut; i++) put_item(kw[i], rand_end());
      if (cut < kw.len()) begin
        case ($urandom_range(0, 2))
          0: put_item(8'($urandom_range(0, 255)), rand_end());
          1: put_item(rand_letter(), rand_end());
          default: put_item(rand_separator(), rand_end());
        endcase
        // a broken keyword often halts; end the source soon after
        if ($urandom_range(0, 1)) put_item(rand_separator(), 1'b1);
      end
    end else if (sel < 80) begin
      put_item(rand_separator(), rand_end());
      if ($urandom_range(0, 1)) put_item(CH_SPACE, rand_end());
    end else if (sel < 88) begin
      n = $urandom_range(1, 3);
      repeat (n) put_item($urandom_range(0, 1) ? CH_SPACE : CH_NL, rand_end());
    end else begin
      put_item(8'($urandom_range(0, 255)), rand_end());
      if ($urandom_range(0, 1)) put_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int  k;
    int  kinds_cnt;
    bit  long_done;
    clear_scanner();
    long_done = 1'b0;

    // Directed: identifier ended by punctuation, percent mismatch with replay,
    // at-word over a newline, single-byte tokens, unterminated block at end
    // with byte extremes, unknown byte halt, open percent lookahead at end
    put_item("a", 1'b0);
    put_item("b", 1'b0);
    put_item(CH_COLON, 1'b0);
    put_item(CH_PCT, 1'b0);
    put_item(CH_LC_C, 1'b0);
    put_item("x", 1'b0);
    put_item(CH_AT, 1'b0);
    put_item(CH_LC_P, 1'b0);
    put_item(CH_NL, 1'b0);
    put_item(CH_SPACE, 1'b0);
    put_item(CH_LESS, 1'b0);
    put_item(CH_GREAT, 1'b0);
    put_item(CH_BAR, 1'b0);
    put_item(CH_SEMI, 1'b0);
    put_item(CH_SPACE, 1'b0);
    put_item(CH_LBRACE, 1'b0);
    put_item(8'hFF, 1'b0);
    put_item(8'h00, 1'b1);
    put_item(CH_UNDER, 1'b0);
    put_item("z", 1'b1);
    put_item(CH_PCT, 1'b0);
    put_item(CH_LC_U, 1'b1);

    // Random fragments, with one block long enough to saturate the length
    while (source_q.size() < RANDOM_ITEMS) begin
      if (!long_done && source_q.size() > RANDOM_ITEMS / 4) begin
        put_item(CH_LBRACE, 1'b0);
        repeat (LONG_BLOCK_LEN) put_item(rand_except(CH_RBRACE), 1'b0);
        put_item(CH_RBRACE, 1'b0);
        long_done = 1'b1;
      end else begin
        add_fragment();
      end
    end
    source_q[source_q.size() - 1].end_of_input = 1'b1;
    total_items = source_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Swap the idling sides after a third of the items, then stop idling
    while (accepted_cnt < total_items / 3) @(posedge clk);
    tx_idle_pct = 62;
    rx_idle_pct = 36;
    phase = 1;
    while (accepted_cnt < (2 * total_items) / 3) @(posedge clk);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase = 2;

    // Drain the outstanding records, then watch for strays
    while (accepted_cnt < total_items) @(posedge clk);
    while (token_records_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    kinds_cnt = 0;
    for (k = 0; k < 15; k++) kinds_cnt += kinds_seen[k];
    $display("Covered %0d source items and %0d token records; %0d of 15 token kinds closed.",
             accepted_cnt, record_cnt, kinds_cnt);
    if (mismatch_cnt == 0 && token_records_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d records never arrived", mismatch_cnt, token_records_q.size());
      $display("status: fail");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d of %0d items accepted", $time, accepted_cnt, total_items);
    $display("status: fail");
    $finish;
  end

endmodule
